// ===== design/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg: shared definitions of the length-prefixed frame deframer
// Holds widths, reset values, the CRC-16/XMODEM byte update and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int LEN_W         = 24;   // payload length width (16..24)
    localparam int CFG_W         = 24;   // max_payload_length register width
    localparam int HDR_DEPTH     = 4;    // header bytes held while hunting
    localparam int HDR_CNT_W     = 3;    // header count, holds 0..HDR_DEPTH
    localparam int HDR_IDX_W     = 2;    // index into the header buffer

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(10000);
    localparam logic [15:0]      CRC_POLY      = 16'h1021;
    localparam logic [7:0]       MARKER_LEN1   = 8'd2;
    localparam logic [7:0]       MARKER_LEN2   = 8'd3;
    localparam logic [7:0]       MARKER_LEN3   = 8'd4;
    localparam logic [7:0]       TERMINATOR    = 8'd3;

    // Result kind loaded into the output register
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_PAY,
        OUT_DONE
    } out_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     hdr_append;   // push the accepted byte into the header buffer
        logic     hdr_drop;     // discard the first header byte
        logic     commit;       // valid header: clear buffer, start the frame
        logic     take_pay;     // run a payload byte through the CRC
        logic     pay_held;     // payload byte comes from the held input byte
        logic     crc_hi;       // capture received CRC high byte
        logic     crc_lo;       // capture received CRC low byte
        logic     out_load;     // load the output register
        out_sel_t out_sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;      // header buffer empty
        logic is_marker;     // first header byte is a start marker
        logic incomplete;    // marker needs more bytes than stored
        logic len_ok;        // length is nonzero, fits and is within max
        logic leftover;      // one byte stored past the header
        logic len_one;       // header length is one
        logic last_byte;     // current payload byte is the last one
    } dp_sts_t;

    // CRC-16/XMODEM over one byte, MSB first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== design/lpfd_datapath.sv =====
// ----------------------------------------------------------------------------
// lpfd_datapath: header buffer, length check, CRC and output register
// Executes the controller's commands and reports header and frame status.
// ----------------------------------------------------------------------------
module lpfd_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [lpfd_pkg::CFG_W-1:0]  cfg_data,
    input  logic [7:0]                  rx_byte,
    input  logic                        in_xfer,
    input  lpfd_pkg::dp_cmd_t           cmd,
    output lpfd_pkg::dp_sts_t           sts,
    output logic [7:0]                  payload_byte,
    output logic                        payload_valid,
    output logic                        frame_done,
    output logic                        frame_good
);

    logic [lpfd_pkg::CFG_W-1:0]     max_len_reg;
    logic [7:0]                     hdr_reg [lpfd_pkg::HDR_DEPTH];
    logic [7:0]                     hdr_next [lpfd_pkg::HDR_DEPTH];
    logic [lpfd_pkg::HDR_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                     held_reg;
    logic [lpfd_pkg::LEN_W-1:0]     left_reg, left_next;
    logic [15:0]                    crc_reg, crc_next;
    logic [15:0]                    rcv_reg, rcv_next;
    logic [7:0]                     pay_byte_reg, pay_byte_next;
    logic                           pay_valid_reg, pay_valid_next;
    logic                           done_reg, done_next;
    logic                           good_reg, good_next;

    logic [7:0]                     head;
    logic [lpfd_pkg::HDR_CNT_W-1:0] need;
    logic [23:0]                    raw_len;
    logic [lpfd_pkg::LEN_W-1:0]     len;
    logic                           len_fits;
    logic [7:0]                     pay_src;
    logic [15:0]                    crc_base;

    // Decode the header at the front of the buffer
    always_comb
    begin
        head = hdr_reg[0];
        need = head[lpfd_pkg::HDR_CNT_W-1:0];
        case (head)
            lpfd_pkg::MARKER_LEN1: raw_len = {16'h0000, hdr_reg[1]};
            lpfd_pkg::MARKER_LEN2: raw_len = {8'h00, hdr_reg[1], hdr_reg[2]};
            default:               raw_len = {hdr_reg[1], hdr_reg[2], hdr_reg[3]};
        endcase
        len_fits = (raw_len >> lpfd_pkg::LEN_W) == 24'h000000;
        len      = raw_len[lpfd_pkg::LEN_W-1:0];

        sts.cnt_zero   = (cnt_reg == '0);
        sts.is_marker  = (head == lpfd_pkg::MARKER_LEN1) ||
                         (head == lpfd_pkg::MARKER_LEN2) ||
                         (head == lpfd_pkg::MARKER_LEN3);
        sts.incomplete = (cnt_reg < need);
        sts.leftover   = (cnt_reg > need);
        sts.len_ok     = (raw_len != 24'h000000) && len_fits &&
                         (raw_len <= 24'(max_len_reg));
        sts.len_one    = (raw_len == 24'h000001);
        sts.last_byte  = (left_reg <= lpfd_pkg::LEN_W'(1));
    end

    // Payload byte source and CRC start value
    assign pay_src  = cmd.pay_held ? held_reg : rx_byte;
    assign crc_base = cmd.commit ? 16'h0000 : crc_reg;

    // Next values of the header buffer, frame counters and output register
    always_comb
    begin
        for (int i = 0; i < lpfd_pkg::HDR_DEPTH; i++)
            hdr_next[i] = hdr_reg[i];
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        crc_next       = crc_reg;
        rcv_next       = rcv_reg;
        pay_byte_next  = pay_byte_reg;
        pay_valid_next = pay_valid_reg;
        done_next      = done_reg;
        good_next      = good_reg;

        // Append a hunted byte, making room when the buffer is full
        if (cmd.hdr_append) begin
            if (cnt_reg == lpfd_pkg::HDR_CNT_W'(lpfd_pkg::HDR_DEPTH)) begin
                for (int i = 0; i < lpfd_pkg::HDR_DEPTH - 1; i++)
                    hdr_next[i] = hdr_reg[i+1];
                hdr_next[lpfd_pkg::HDR_DEPTH-1] = rx_byte;
            end else begin
                hdr_next[cnt_reg[lpfd_pkg::HDR_IDX_W-1:0]] = rx_byte;
                cnt_next = cnt_reg + lpfd_pkg::HDR_CNT_W'(1);
            end
        end

        // Drop the first header byte
        if (cmd.hdr_drop) begin
            for (int i = 0; i < lpfd_pkg::HDR_DEPTH - 1; i++)
                hdr_next[i] = hdr_reg[i+1];
            hdr_next[lpfd_pkg::HDR_DEPTH-1] = 8'h00;
            if (cnt_reg != '0)
                cnt_next = cnt_reg - lpfd_pkg::HDR_CNT_W'(1);
        end

        // Start a frame
        if (cmd.commit) begin
            for (int i = 0; i < lpfd_pkg::HDR_DEPTH; i++)
                hdr_next[i] = 8'h00;
            cnt_next  = '0;
            left_next = len;
            crc_next  = 16'h0000;
            rcv_next  = 16'h0000;
        end

        // Advance CRC and remaining count on a payload byte
        if (cmd.take_pay) begin
            crc_next = lpfd_pkg::crc16_update(crc_base, pay_src);
            if (cmd.commit)
                left_next = len - lpfd_pkg::LEN_W'(1);
            else if (left_reg != '0)
                left_next = left_reg - lpfd_pkg::LEN_W'(1);
        end

        // Capture the received CRC
        if (cmd.crc_hi)
            rcv_next = {rx_byte, 8'h00};
        if (cmd.crc_lo)
            rcv_next = {rcv_reg[15:8], rx_byte};

        // Load the result
        if (cmd.out_load) begin
            case (cmd.out_sel)
                lpfd_pkg::OUT_PAY: begin
                    pay_byte_next  = pay_src;
                    pay_valid_next = 1'b1;
                    done_next      = 1'b0;
                    good_next      = 1'b0;
                end
                lpfd_pkg::OUT_DONE: begin
                    pay_byte_next  = 8'h00;
                    pay_valid_next = 1'b0;
                    done_next      = 1'b1;
                    good_next      = (rx_byte == lpfd_pkg::TERMINATOR) &&
                                     (rcv_reg == crc_reg);
                end
                default: begin
                    pay_byte_next  = 8'h00;
                    pay_valid_next = 1'b0;
                    done_next      = 1'b0;
                    good_next      = 1'b0;
                end
            endcase
        end
    end

    // Hold configuration and datapath state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg   <= lpfd_pkg::MAX_LEN_RESET;
            for (int i = 0; i < lpfd_pkg::HDR_DEPTH; i++)
                hdr_reg[i] <= 8'h00;
            cnt_reg       <= '0;
            held_reg      <= 8'h00;
            left_reg      <= '0;
            crc_reg       <= 16'h0000;
            rcv_reg       <= 16'h0000;
            pay_byte_reg  <= 8'h00;
            pay_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            good_reg      <= 1'b0;
        end else begin
            if (cfg_write)
                max_len_reg <= cfg_data;
            if (in_xfer)
                held_reg <= rx_byte;
            for (int i = 0; i < lpfd_pkg::HDR_DEPTH; i++)
                hdr_reg[i] <= hdr_next[i];
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            crc_reg       <= crc_next;
            rcv_reg       <= rcv_next;
            pay_byte_reg  <= pay_byte_next;
            pay_valid_reg <= pay_valid_next;
            done_reg      <= done_next;
            good_reg      <= good_next;
        end
    end

    assign payload_byte  = pay_byte_reg;
    assign payload_valid = pay_valid_reg;
    assign frame_done    = done_reg;
    assign frame_good    = good_reg;

endmodule

// ===== design/lpfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpfd_ctrl: frame phase controller
// Sequences hunting, header scan, payload, CRC and terminator phases and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module lpfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                in_xfer,
    input  lpfd_pkg::dp_sts_t   sts,
    output lpfd_pkg::dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_SCAN,
        S_PAYLOAD,
        S_CRC_HI,
        S_CRC_LO,
        S_TERM
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Accept only when the output register is empty or draining
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg != S_SCAN) && slot_free;
    assign in_xfer   = in_valid && in_ready;

    // Issue commands and pick the next phase
    always_comb
    begin
        cmd        = '0;
        cmd.out_sel = lpfd_pkg::OUT_NONE;
        state_next = state_reg;

        case (state_reg)
            S_HUNT: begin
                if (in_xfer) begin
                    cmd.hdr_append = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (slot_free) begin
                    if (sts.cnt_zero || (sts.is_marker && sts.incomplete)) begin
                        cmd.out_load = 1'b1;
                        state_next   = S_HUNT;
                    end else if (!sts.is_marker || !sts.len_ok) begin
                        cmd.hdr_drop = 1'b1;
                    end else if (sts.leftover) begin
                        // the byte just accepted is the first payload byte
                        cmd.commit   = 1'b1;
                        cmd.take_pay = 1'b1;
                        cmd.pay_held = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = lpfd_pkg::OUT_PAY;
                        state_next   = sts.len_one ? S_CRC_HI : S_PAYLOAD;
                    end else begin
                        cmd.commit   = 1'b1;
                        cmd.out_load = 1'b1;
                        state_next   = S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD: begin
                if (in_xfer) begin
                    cmd.take_pay = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = lpfd_pkg::OUT_PAY;
                    if (sts.last_byte)
                        state_next = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                if (in_xfer) begin
                    cmd.crc_hi   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_CRC_LO;
                end
            end
            S_CRC_LO: begin
                if (in_xfer) begin
                    cmd.crc_lo   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_TERM;
                end
            end
            S_TERM: begin
                if (in_xfer) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = lpfd_pkg::OUT_DONE;
                    state_next   = S_HUNT;
                end
            end
            default: begin
                state_next = S_HUNT;
            end
        endcase

        // Set on a new result, clear when the consumer takes it
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold phase and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_HUNT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/length_prefixed_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_top: length-prefixed frame deframer
// Hunts for a start marker and length header, streams out the payload,
// checks CRC-16/XMODEM and the terminator, and flags each finished frame.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one result on the output channel.
// While hunting, the header buffer is examined one entry per cycle while
// the output register has room, and in_ready stays low during that scan,
// which drops at most four header bytes. The output register lets a new
// byte enter in the cycle its predecessor's result is taken. frame_good
// is only meaningful with frame_done; consumers discard frames that are
// not good. max_payload_length resets to 10000 and is written through
// cfg_write / cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [lpfd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  payload_byte,
    output logic                        payload_valid,
    output logic                        frame_done,
    output logic                        frame_good
);

    lpfd_pkg::dp_cmd_t cmd;
    lpfd_pkg::dp_sts_t sts;
    logic              in_xfer;

    // Phase controller
    lpfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_xfer   (in_xfer),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Header, CRC and result datapath
    lpfd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .rx_byte       (rx_byte),
        .in_xfer       (in_xfer),
        .cmd           (cmd),
        .sts           (sts),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .frame_done    (frame_done),
        .frame_good    (frame_good)
    );

endmodule
